/* design/assert_macros.svh */
// Assertion macros used by the timer datapath (otd_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

/* design/otd_pkg.sv */
// Types and constants shared by the one-shot deadline timer modules.
`default_nettype none

package otd_pkg;

  // Opcode carried in the func field of an input item.
  localparam logic FUNC_PROGRAM = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // Configuration register indexes.
  localparam logic REG_RESOLUTION = 1'b0;
  localparam logic REG_MAX_DELTA  = 1'b1;

  localparam int TIME_W = 64;
  localparam int CFG_W  = 32;

  // Resolution in microseconds is resolution_ns / 1000, computed as a
  // multiply by ceil(2^38 / 1000) followed by a 38-bit shift. The error term
  // stays below 1/1000 for every 32-bit input, so the quotient is exact.
  localparam int NS_PER_US   = 1000;
  localparam int RES_SHIFT   = 38;
  localparam int RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
  localparam int RES_PROD_W  = CFG_W + RECIP_W;
  localparam int RES_W       = RES_PROD_W - RES_SHIFT;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] target_us;
  } otd_in_t;

  typedef struct packed {
    logic              fired;
    logic              is_armed;
    logic [TIME_W-1:0] stored_deadline_us;
  } otd_out_t;

  // Settings handed from the configuration block to the datapath.
  typedef struct packed {
    logic [RES_W-1:0] res_us;
    logic [CFG_W-1:0] max_delta_us;
  } otd_cfg_t;

endpackage

`default_nettype wire

/* design/otd_cfg.sv */
// Configuration registers of the deadline timer, with the resolution kept in microseconds.
`default_nettype none

module otd_cfg (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  input  wire logic                    cfg_index,
  input  wire logic [otd_pkg::CFG_W-1:0] cfg_data,
  output otd_pkg::otd_cfg_t            cfg
);

  logic [otd_pkg::RES_PROD_W-1:0] res_prod;
  logic [otd_pkg::RES_W-1:0]      res_quot;
  logic [otd_pkg::RES_W-1:0]      res_us;
  logic [otd_pkg::CFG_W-1:0]      max_delta_us;

  // Divide the written value by 1000 on the way in and floor it at one.
  assign res_prod = otd_pkg::RES_PROD_W'(cfg_data) *
                    otd_pkg::RES_PROD_W'(otd_pkg::RECIP_1000);
  assign res_quot = res_prod[otd_pkg::RES_SHIFT +: otd_pkg::RES_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_us       <= otd_pkg::RES_W'(1);
      max_delta_us <= otd_pkg::CFG_W'(1000000);
    end else if (cfg_valid) begin
      case (cfg_index)
        otd_pkg::REG_RESOLUTION: begin
          res_us <= (res_quot == '0) ? otd_pkg::RES_W'(1) : res_quot;
        end
        otd_pkg::REG_MAX_DELTA: begin
          max_delta_us <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.res_us       = res_us;
  assign cfg.max_delta_us = max_delta_us;

endmodule

`default_nettype wire

/* design/otd_core.sv */
// Deadline datapath: timer state, program and tick logic, and the result register.
`default_nettype none
`include "assert_macros.svh"

module otd_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  otd_pkg::otd_cfg_t       cfg,
  input  wire logic               item_valid,
  input  otd_pkg::otd_in_t        item,
  output logic                    take,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output otd_pkg::otd_out_t       out_item
);

  localparam int TW = otd_pkg::TIME_W;
  localparam int RW = otd_pkg::RES_W;

  logic          load;
  logic [TW-1:0] next_deadline;
  logic [TW-1:0] next_deadline_next;
  logic          armed;
  logic          armed_next;
  logic          fired_next;
  logic [TW-1:0] dist_raw;
  logic [TW-1:0] dist_pos;
  logic [TW-1:0] dist_min;
  logic [TW-1:0] dist_cap;
  logic [TW-1:0] max_ext;
  logic          below_res;
  logic [TW-1:0] tick_diff;
  logic          reached;

  // The result register is free when empty or when its item leaves now.
  assign take = !out_valid || !out_stall;
  assign load = item_valid && take;

  // Program path: distance to the deadline, clamped to [res, max] or zero.
  assign dist_raw  = item.target_us - item.now_us;
  assign dist_pos  = dist_raw[TW-1] ? '0 : dist_raw;
  assign below_res = (dist_pos[TW-1:RW] == '0) && (dist_pos[RW-1:0] < cfg.res_us);
  assign dist_min  = below_res ? '0 : dist_pos;
  assign max_ext   = TW'(cfg.max_delta_us);
  assign dist_cap  = (dist_min > max_ext) ? max_ext : dist_min;

  // Tick path: wrap-aware signed compare of the stored deadline against now.
  assign tick_diff = next_deadline - item.now_us;
  assign reached   = armed && ((tick_diff == '0) || tick_diff[TW-1]);

  always_comb begin
    next_deadline_next = next_deadline;
    armed_next         = armed;
    fired_next         = 1'b0;
    case (item.func)
      otd_pkg::FUNC_PROGRAM: begin
        if (item.target_us == '0) begin
          next_deadline_next = '0;
          armed_next         = 1'b0;
        end else begin
          next_deadline_next = item.now_us + dist_cap;
          armed_next         = 1'b1;
        end
      end
      otd_pkg::FUNC_TICK: begin
        if (reached) begin
          armed_next = 1'b0;
          fired_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_deadline <= '0;
      armed         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (load) begin
        next_deadline <= next_deadline_next;
        armed         <= armed_next;
      end
      if (take) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.fired              <= fired_next;
      out_item.is_armed           <= armed_next;
      out_item.stored_deadline_us <= next_deadline_next;
    end
  end

  `ASSERT_RST(a_fire_disarms, clk, rst, out_valid && out_item.fired |-> !out_item.is_armed, "fired result still armed")
  `ASSERT_RST(a_result_tracks_state, clk, rst, $past(load) |-> out_item.is_armed == armed, "result armed flag differs from state")
  `ASSERT_RST(a_program_arms, clk, rst, load && item.func == otd_pkg::FUNC_PROGRAM && item.target_us != '0 |=> armed, "program item left the timer disarmed")
  `ASSERT_RST(a_cap_holds, clk, rst, load && item.func == otd_pkg::FUNC_PROGRAM && item.target_us != '0 |=> (next_deadline - $past(item.now_us)) <= TW'($past(cfg.max_delta_us)), "stored deadline beyond cap")
  `ASSERT_RST(a_tick_keeps_deadline, clk, rst, load && item.func == otd_pkg::FUNC_TICK |=> $stable(next_deadline), "tick changed the stored deadline")

endmodule

`default_nettype wire

/* design/one_shot_deadline_timer.sv */
// Top level of the one-shot deadline timer: input register, configuration and datapath.
`default_nettype none

// An accepted item goes from the input register through the datapath to the result register.
// Throughput: one item per cycle unless the result channel stalls; the input register and
// the result register let a new item enter while a finished result still waits downstream.
// The rate is set by the single datapath stage that computes and updates the timer state.
// Reset (synchronous, active high) disarms the timer, clears the deadline, empties both
// registers and loads a resolution of 1000 ns and a maximum distance of 1000000 us.

module one_shot_deadline_timer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Item channel in.
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  otd_pkg::otd_in_t               in_item,
  // Result channel out.
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output otd_pkg::otd_out_t              out_item,
  // Configuration write channel.
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [otd_pkg::CFG_W-1:0] cfg_data
);

  logic              item_valid;
  otd_pkg::otd_in_t  item;
  logic              take;
  otd_pkg::otd_cfg_t cfg;

  // Register writes complete at once; the user must send them only while idle (unchecked).
  assign cfg_ready = 1'b1;

  // The input register stalls only when it holds an item that the datapath
  // cannot take this cycle because the result register is full and stalled.
  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  // The payload register needs no reset; it loads whenever a new item is accepted.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

  otd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  otd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
